// ===== rtl/sit_pkg.sv =====
package sit_pkg;

  // Default coordinate width of each endpoint field
  localparam int unsigned COORD_BITS_DEF = 16;

  // Number of coordinate fields in one input beat
  localparam int unsigned NUM_COORDS = 8;

  // Number of orientation tests per segment pair
  localparam int unsigned NUM_TESTS = 4;

  // Test slots: which endpoint is tested against which segment
  localparam int unsigned T_B0_ON_A = 0;
  localparam int unsigned T_B1_ON_A = 1;
  localparam int unsigned T_A0_ON_B = 2;
  localparam int unsigned T_A1_ON_B = 3;

  // Bounding-box hits, one per endpoint tested against the other segment
  typedef struct packed {
    logic a1_on_b;
    logic a0_on_b;
    logic b1_on_a;
    logic b0_on_a;
  } box_hits_t;

  // Orientation sign of a point against a directed line
  typedef enum logic [1:0] {
    ORI_ZERO = 2'd0,
    ORI_POS  = 2'd1,
    ORI_NEG  = 2'd2
  } orient_t;

endpackage

// ===== rtl/segment_intersection_test.sv =====
// Channel | Direction | Ports                           | Beat content
// --------+-----------+---------------------------------+-------------------------------
// input   | slave     | in_tvalid, in_tready, in_tdata  | eight endpoint coordinates
// result  | master    | out_tvalid, out_tready, out_tdata | segments_meet flag
//
// Three register stages: endpoint differences and box compares, cross-product
// multiplies, sign compare and decision into the output register.
// One beat per cycle sustained while out_tready stays high; out_tvalid rises once the beat
// has passed through the difference, product and output registers.
// rst_n is synchronous, active low, and clears only the stage valid bits.
// A stalled output holds its beat; each stage refills as soon as it empties.
module segment_intersection_test import sit_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_TDATA_W = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // segments_meet
  output logic [7:0]            out_tdata
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [CB-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
  logic signed [CB-1:0] b_start_x, b_start_y, b_end_x, b_end_y;

  logic               s1_valid, s1_ready;
  logic signed [CB:0] dir_a_x, dir_a_y, dir_b_x, dir_b_y;
  logic signed [CB:0] off_x [NUM_TESTS];
  logic signed [CB:0] off_y [NUM_TESTS];
  box_hits_t          s1_box;

  logic                 s2_valid, s2_ready;
  logic signed [PW-1:0] lhs [NUM_TESTS];
  logic signed [PW-1:0] rhs [NUM_TESTS];
  box_hits_t            s2_box;

  logic segments_meet;

  // Unpack the input beat
  assign a_start_x = in_tdata[0*CB +: CB];
  assign a_start_y = in_tdata[1*CB +: CB];
  assign a_end_x   = in_tdata[2*CB +: CB];
  assign a_end_y   = in_tdata[3*CB +: CB];
  assign b_start_x = in_tdata[4*CB +: CB];
  assign b_start_y = in_tdata[5*CB +: CB];
  assign b_end_x   = in_tdata[6*CB +: CB];
  assign b_end_y   = in_tdata[7*CB +: CB];

  sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .a0_x      (a_start_x),
    .a0_y      (a_start_y),
    .a1_x      (a_end_x),
    .a1_y      (a_end_y),
    .b0_x      (b_start_x),
    .b0_y      (b_start_y),
    .b1_x      (b_end_x),
    .b1_y      (b_end_y),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .dir_a_x   (dir_a_x),
    .dir_a_y   (dir_a_y),
    .dir_b_x   (dir_b_x),
    .dir_b_y   (dir_b_y),
    .off_x     (off_x),
    .off_y     (off_y),
    .box       (s1_box)
  );

  sit_prod #(.COORD_BITS(COORD_BITS)) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .dir_a_x   (dir_a_x),
    .dir_a_y   (dir_a_y),
    .dir_b_x   (dir_b_x),
    .dir_b_y   (dir_b_y),
    .off_x     (off_x),
    .off_y     (off_y),
    .box_in    (s1_box),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .lhs       (lhs),
    .rhs       (rhs),
    .box_out   (s2_box)
  );

  sit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .lhs       (lhs),
    .rhs       (rhs),
    .box       (s2_box),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .meet      (segments_meet)
  );

  // Pack the result beat
  assign out_tdata = {7'b0, segments_meet};

endmodule

// ===== rtl/sit_diff.sv =====
module sit_diff import sit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] a0_x,
  input  logic signed [COORD_BITS-1:0] a0_y,
  input  logic signed [COORD_BITS-1:0] a1_x,
  input  logic signed [COORD_BITS-1:0] a1_y,
  input  logic signed [COORD_BITS-1:0] b0_x,
  input  logic signed [COORD_BITS-1:0] b0_y,
  input  logic signed [COORD_BITS-1:0] b1_x,
  input  logic signed [COORD_BITS-1:0] b1_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   dir_a_x,
  output logic signed [COORD_BITS:0]   dir_a_y,
  output logic signed [COORD_BITS:0]   dir_b_x,
  output logic signed [COORD_BITS:0]   dir_b_y,
  output logic signed [COORD_BITS:0]   off_x [NUM_TESTS],
  output logic signed [COORD_BITS:0]   off_y [NUM_TESTS],
  output box_hits_t                    box
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1;
  logic                 valid_r;
  logic signed [DW-1:0] dir_a_x_r, dir_a_y_r, dir_b_x_r, dir_b_y_r;
  logic signed [DW-1:0] off_x_r [NUM_TESTS];
  logic signed [DW-1:0] off_y_r [NUM_TESTS];
  logic signed [DW-1:0] off_x_nxt [NUM_TESTS];
  logic signed [DW-1:0] off_y_nxt [NUM_TESTS];
  box_hits_t            box_r, box_nxt;
  logic                 load;

  // Sign-extend by one bit so each difference is exact
  assign xa0 = {a0_x[COORD_BITS-1], a0_x};
  assign ya0 = {a0_y[COORD_BITS-1], a0_y};
  assign xa1 = {a1_x[COORD_BITS-1], a1_x};
  assign ya1 = {a1_y[COORD_BITS-1], a1_y};
  assign xb0 = {b0_x[COORD_BITS-1], b0_x};
  assign yb0 = {b0_y[COORD_BITS-1], b0_y};
  assign xb1 = {b1_x[COORD_BITS-1], b1_x};
  assign yb1 = {b1_y[COORD_BITS-1], b1_y};

  // Offsets of each tested point from the far end of the other segment
  always_comb begin
    off_x_nxt[T_B0_ON_A] = xb0 - xa1;
    off_y_nxt[T_B0_ON_A] = yb0 - ya1;
    off_x_nxt[T_B1_ON_A] = xb1 - xa1;
    off_y_nxt[T_B1_ON_A] = yb1 - ya1;
    off_x_nxt[T_A0_ON_B] = xa0 - xb1;
    off_y_nxt[T_A0_ON_B] = ya0 - yb1;
    off_x_nxt[T_A1_ON_B] = xa1 - xb1;
    off_y_nxt[T_A1_ON_B] = ya1 - yb1;
  end

  // Bounding-box membership of each endpoint in the other segment's box
  always_comb begin
    box_nxt.b0_on_a = (b0_x >= a0_x || b0_x >= a1_x) && (b0_x <= a0_x || b0_x <= a1_x) &&
                      (b0_y >= a0_y || b0_y >= a1_y) && (b0_y <= a0_y || b0_y <= a1_y);
    box_nxt.b1_on_a = (b1_x >= a0_x || b1_x >= a1_x) && (b1_x <= a0_x || b1_x <= a1_x) &&
                      (b1_y >= a0_y || b1_y >= a1_y) && (b1_y <= a0_y || b1_y <= a1_y);
    box_nxt.a0_on_b = (a0_x >= b0_x || a0_x >= b1_x) && (a0_x <= b0_x || a0_x <= b1_x) &&
                      (a0_y >= b0_y || a0_y >= b1_y) && (a0_y <= b0_y || a0_y <= b1_y);
    box_nxt.a1_on_b = (a1_x >= b0_x || a1_x >= b1_x) && (a1_x <= b0_x || a1_x <= b1_x) &&
                      (a1_y >= b0_y || a1_y >= b1_y) && (a1_y <= b0_y || a1_y <= b1_y);
  end

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Advance the valid bit whenever the stage can move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture the payload of an accepted beat
  always_ff @(posedge clk) begin
    if (load) begin
      dir_a_x_r <= xa1 - xa0;
      dir_a_y_r <= ya1 - ya0;
      dir_b_x_r <= xb1 - xb0;
      dir_b_y_r <= yb1 - yb0;
      off_x_r   <= off_x_nxt;
      off_y_r   <= off_y_nxt;
      box_r     <= box_nxt;
    end
  end

  assign out_valid = valid_r;
  assign dir_a_x   = dir_a_x_r;
  assign dir_a_y   = dir_a_y_r;
  assign dir_b_x   = dir_b_x_r;
  assign dir_b_y   = dir_b_y_r;
  assign off_x     = off_x_r;
  assign off_y     = off_y_r;
  assign box       = box_r;

endmodule

// ===== rtl/sit_prod.sv =====
module sit_prod import sit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_BITS:0]       dir_a_x,
  input  logic signed [COORD_BITS:0]       dir_a_y,
  input  logic signed [COORD_BITS:0]       dir_b_x,
  input  logic signed [COORD_BITS:0]       dir_b_y,
  input  logic signed [COORD_BITS:0]       off_x [NUM_TESTS],
  input  logic signed [COORD_BITS:0]       off_y [NUM_TESTS],
  input  box_hits_t                        box_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [2*COORD_BITS+1:0]   lhs [NUM_TESTS],
  output logic signed [2*COORD_BITS+1:0]   rhs [NUM_TESTS],
  output box_hits_t                        box_out
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic                 valid_r;
  logic signed [PW-1:0] lhs_r [NUM_TESTS];
  logic signed [PW-1:0] rhs_r [NUM_TESTS];
  logic signed [PW-1:0] lhs_nxt [NUM_TESTS];
  logic signed [PW-1:0] rhs_nxt [NUM_TESTS];
  box_hits_t            box_r;
  logic                 load;

  // Cross-product terms: line dy times offset dx against line dx times offset dy
  always_comb begin
    for (int k = 0; k < NUM_TESTS; k++) begin
      if (k == T_B0_ON_A || k == T_B1_ON_A) begin
        lhs_nxt[k] = dir_a_y * off_x[k];
        rhs_nxt[k] = dir_a_x * off_y[k];
      end else begin
        lhs_nxt[k] = dir_b_y * off_x[k];
        rhs_nxt[k] = dir_b_x * off_y[k];
      end
    end
  end

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Advance the valid bit whenever the stage can move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Register the products
  always_ff @(posedge clk) begin
    if (load) begin
      lhs_r <= lhs_nxt;
      rhs_r <= rhs_nxt;
      box_r <= box_in;
    end
  end

  assign out_valid = valid_r;
  assign lhs       = lhs_r;
  assign rhs       = rhs_r;
  assign box_out   = box_r;

endmodule

// ===== rtl/sit_decide.sv =====
module sit_decide import sit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [2*COORD_BITS+1:0] lhs [NUM_TESTS],
  input  logic signed [2*COORD_BITS+1:0] rhs [NUM_TESTS],
  input  box_hits_t                      box,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           meet
);

  orient_t ori [NUM_TESTS];
  logic    valid_r;
  logic    meet_r, meet_nxt;
  logic    straddle;
  logic    touch;
  logic    load;

  // Turn each product pair into an orientation sign
  always_comb begin
    for (int k = 0; k < NUM_TESTS; k++) begin
      if (lhs[k] == rhs[k]) begin
        ori[k] = ORI_ZERO;
      end else if (lhs[k] > rhs[k]) begin
        ori[k] = ORI_POS;
      end else begin
        ori[k] = ORI_NEG;
      end
    end
  end

  // Proper crossing, or a collinear endpoint inside the other segment's box
  always_comb begin
    straddle = (ori[T_B0_ON_A] != ori[T_B1_ON_A]) && (ori[T_A0_ON_B] != ori[T_A1_ON_B]);
    touch    = (ori[T_B0_ON_A] == ORI_ZERO && box.b0_on_a) ||
               (ori[T_B1_ON_A] == ORI_ZERO && box.b1_on_a) ||
               (ori[T_A0_ON_B] == ORI_ZERO && box.a0_on_b) ||
               (ori[T_A1_ON_B] == ORI_ZERO && box.a1_on_b);
    meet_nxt = straddle || touch;
  end

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meet_r <= meet_nxt;
    end
  end

  assign out_valid = valid_r;
  assign meet      = meet_r;

endmodule
